// File: rtl/core/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared codes, widths and the step duration table of the buzzer sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

	localparam int KIND_W           = 2;
	localparam int PAT_W            = 3;
	localparam int STEP_W           = 3;
	localparam int DUR_W            = 8;
	localparam int STEP_SLOTS       = 6;
	localparam int ELAPSED_BITS_DEF = 16;

	localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STOP    = 2'd2;

	localparam logic [PAT_W-1:0] PAT_OFF         = 3'd0;
	localparam logic [PAT_W-1:0] PAT_ALERT       = 3'd1;
	localparam logic [PAT_W-1:0] PAT_CONFIRM     = 3'd2;
	localparam logic [PAT_W-1:0] PAT_SETUP_ENTER = 3'd3;
	localparam logic [PAT_W-1:0] PAT_SETUP_EXIT  = 3'd4;

	// Step duration in ms; zero marks the end of a pattern.
	function automatic logic [DUR_W-1:0] step_duration(
		input logic [PAT_W-1:0]  pat,
		input logic [STEP_W-1:0] step
	);
		logic [DUR_W-1:0] dur;
		dur = '0;
		case (pat)
			PAT_ALERT: begin
				if (step == 3'd0 || step == 3'd1) dur = 8'd200;
			end
			PAT_CONFIRM: begin
				if (step == 3'd0) dur = 8'd100;
			end
			PAT_SETUP_ENTER: begin
				if (step == 3'd0 || step == 3'd2) dur = 8'd100;
				else if (step == 3'd1) dur = 8'd80;
			end
			PAT_SETUP_EXIT: begin
				if (step == 3'd0 || step == 3'd2 || step == 3'd4) dur = 8'd80;
				else if (step == 3'd1 || step == 3'd3) dur = 8'd60;
			end
			default: dur = '0;
		endcase
		return dur;
	endfunction

endpackage

// File: rtl/core/buzzer_pattern_sequencer_top.sv
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer_top
// On/off tone pattern sequencer for an active buzzer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, kind, pattern) carries one transaction
//   per event: a 1 ms tick, a pattern request or a stop. Every input
//   transaction yields exactly one output transaction (out_valid/out_ready,
//   buzzer_on, active_pattern, step_index) showing the state after it.
//   Path: an accepted item passes the input register, then the result
//   register, which presents it on the output.
//   Throughput: one item per cycle while the output does not stall. The only
//   loop is the small state update (pattern, step, elapsed count, level)
//   between the input register and the result register.
//   Stall: if out_ready is low, the result register holds and the input
//   register keeps one more item; in_ready drops only when both are full.
//   Reset (arst_n low): pattern off, silent, step and elapsed count zero,
//   both pipeline slots empty. No clearing pass is needed.
//   ELAPSED_BITS sets the width of the saturating millisecond counter.
// ----------------------------------------------------------------------------
module buzzer_pattern_sequencer_top #(
	parameter int ELAPSED_BITS = bps_pkg::ELAPSED_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [bps_pkg::KIND_W-1:0] kind,
	input  logic [bps_pkg::PAT_W-1:0]  pattern,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       buzzer_on,
	output logic [bps_pkg::PAT_W-1:0]  active_pattern,
	output logic [bps_pkg::STEP_W-1:0] step_index
);
	import bps_pkg::*;

	localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = {ELAPSED_BITS{1'b1}};

	// Input register stage
	logic              valid_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [PAT_W-1:0]  pattern_s1;

	// Sequencer state
	logic [PAT_W-1:0]        pat_q;
	logic [STEP_W-1:0]       step_q;
	logic [ELAPSED_BITS-1:0] elapsed_q;
	logic                    level_q;
	logic                    one_shot_q;

	// Result register
	logic              out_valid_q;
	logic              buzzer_q;
	logic [PAT_W-1:0]  active_q;
	logic [STEP_W-1:0] step_out_q;

	logic advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Next state for the item in the input register
	logic [PAT_W-1:0]        pat_d;
	logic [STEP_W-1:0]       step_d;
	logic [ELAPSED_BITS-1:0] elapsed_d;
	logic                    level_d;
	logic                    one_shot_d;
	logic [DUR_W-1:0]        dur;
	logic [ELAPSED_BITS-1:0] elapsed_inc;
	logic [PAT_W-1:0]        req_pat;

	always_comb begin
		pat_d       = pat_q;
		step_d      = step_q;
		elapsed_d   = elapsed_q;
		level_d     = level_q;
		one_shot_d  = one_shot_q;
		dur         = step_duration(pat_q, step_q);
		elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
		// codes above setup exit count as off
		req_pat     = (pattern_s1 > PAT_SETUP_EXIT) ? PAT_OFF : pattern_s1;
		unique case (kind_s1)
			KIND_TICK: begin
				if (pat_q != PAT_OFF) begin
					if (dur == '0) begin
						// end mark: one-shot stops, alert wraps around
						if (one_shot_q) begin
							pat_d   = PAT_OFF;
							level_d = 1'b0;
						end else begin
							step_d    = '0;
							elapsed_d = '0;
							level_d   = 1'b1;
						end
					end else if (elapsed_inc >= ELAPSED_BITS'(dur)) begin
						step_d    = step_q + 1'b1;
						elapsed_d = '0;
						level_d   = !level_q;
					end else begin
						elapsed_d = elapsed_inc;
					end
				end
			end
			KIND_REQUEST: begin
				// same pattern again is ignored, confirm restarts
				if (req_pat != pat_q || req_pat == PAT_CONFIRM) begin
					pat_d      = req_pat;
					step_d     = '0;
					elapsed_d  = '0;
					one_shot_d = (req_pat >= PAT_CONFIRM);
					level_d    = (req_pat != PAT_OFF);
				end
			end
			KIND_STOP: begin
				pat_d   = PAT_OFF;
				level_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			pat_q       <= PAT_OFF;
			step_q      <= '0;
			elapsed_q   <= '0;
			level_q     <= 1'b0;
			one_shot_q  <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				pat_q       <= pat_d;
				step_q      <= step_d;
				elapsed_q   <= elapsed_d;
				level_q     <= level_d;
				one_shot_q  <= one_shot_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1    <= kind;
			pattern_s1 <= pattern;
		end
		if (advance) begin
			buzzer_q   <= level_d;
			active_q   <= pat_d;
			step_out_q <= (pat_d != PAT_OFF) ? step_d : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign buzzer_on      = buzzer_q;
	assign active_pattern = active_q;
	assign step_index     = step_out_q;

	// ---------------------------------------------------------------- checks
	a_silent_when_off: assert property (@(posedge clk) disable iff (!arst_n)
		(pat_q == PAT_OFF) |-> !level_q)
		else $error("buzzer level set while no pattern plays");

	a_one_shot_match: assert property (@(posedge clk) disable iff (!arst_n)
		(pat_q != PAT_OFF) |-> (one_shot_q == (pat_q != PAT_ALERT)))
		else $error("one-shot flag does not match playing pattern");

	a_step_hidden: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && active_pattern == PAT_OFF) |-> (step_index == '0 && !buzzer_on))
		else $error("step or level shown while pattern is off");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with an empty result register");

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the buzzer pattern sequencer: a queue-fed driver,
// a monitor with random back-pressure and an in-bench model of the patterns.
// ----------------------------------------------------------------------------
module tb;

	import bps_pkg::*;

	// ------------------------------------------------------------------
	// Bench constants
	// ------------------------------------------------------------------
	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 6;
	localparam int ELAPSED_BITS   = ELAPSED_BITS_DEF;
	localparam int MAX_WAIT       = 13;      // per-transaction idle draw, 0..MAX_WAIT
	localparam int N_ITEMS        = 750;     // input transactions at least, directed included
	localparam int HOLD_AT        = 300;     // result count that starts the long stall
	localparam int HOLD_CYCLES    = 60;
	localparam int DRAIN_CYCLES   = 8;       // two pipeline slots plus margin
	localparam int MAX_REPORTS    = 200;
	localparam int TIMEOUT_CYCLES = 500_000;

	// kind 3 is not a command; the block must report state unchanged
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// pattern codes past setup exit; the block treats them as off
	localparam logic [PAT_W-1:0] PAT_UNDEF_A = 3'd5;
	localparam logic [PAT_W-1:0] PAT_UNDEF_B = 3'd6;
	localparam logic [PAT_W-1:0] PAT_UNDEF_C = 3'd7;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [PAT_W-1:0]  pattern;
	} buzz_cmd_t;

	typedef struct packed {
		logic              buzzer_on;
		logic [PAT_W-1:0]  active_pattern;
		logic [STEP_W-1:0] step_index;
	} buzz_state_t;

	// ------------------------------------------------------------------
	// DUT signals; every input known from time zero
	// ------------------------------------------------------------------
	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic [KIND_W-1:0] kind      = KIND_TICK;
	logic [PAT_W-1:0]  pattern   = PAT_OFF;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              buzzer_on;
	logic [PAT_W-1:0]  active_pattern;
	logic [STEP_W-1:0] step_index;

	buzzer_pattern_sequencer_top #(
		.ELAPSED_BITS(ELAPSED_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.pattern       (pattern),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.buzzer_on     (buzzer_on),
		.active_pattern(active_pattern),
		.step_index    (step_index)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Bench state
	// ------------------------------------------------------------------
	buzz_cmd_t   pending_cmds[$];     // stimulus not yet offered
	buzz_state_t expected_buzz[$];    // predicted results, oldest first
	int          n_total    = 0;
	int          n_accepted = 0;
	int          n_seen     = 0;
	int          errors     = 0;

	// Model copy of the sequencer state
	logic [PAT_W-1:0]        pat_now    = PAT_OFF;
	logic [STEP_W-1:0]       step_now   = '0;
	logic [ELAPSED_BITS-1:0] ms_in_step = '0;
	logic                    sounding   = 1'b0;
	logic                    one_shot   = 1'b0;

	// Duration of one step in ms, zero at the end mark.
	// Rows are packed with step 0 in the low byte.
	function automatic int step_ms(input logic [PAT_W-1:0] p, input logic [STEP_W-1:0] s);
		logic [STEP_SLOTS-1:0][7:0] row;
		case (p)
			PAT_ALERT:       row = {8'd0, 8'd0, 8'd0, 8'd0, 8'd200, 8'd200};
			PAT_CONFIRM:     row = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd100};
			PAT_SETUP_ENTER: row = {8'd0, 8'd0, 8'd0, 8'd100, 8'd80, 8'd100};
			PAT_SETUP_EXIT:  row = {8'd0, 8'd80, 8'd60, 8'd80, 8'd60, 8'd80};
			default:         row = '0;
		endcase
		if (s >= STEP_SLOTS) return 0;
		return int'(row[s]);
	endfunction

	// Ticks needed to run a pattern to its end mark.
	function automatic int pattern_ms(input logic [PAT_W-1:0] p);
		int sum;
		sum = 0;
		for (int i = 0; i < STEP_SLOTS; i++) sum += step_ms(p, i[STEP_W-1:0]);
		return sum;
	endfunction

	// Apply one accepted transaction to the model and queue the result it yields.
	task automatic predict_buzz(input logic [KIND_W-1:0] k, input logic [PAT_W-1:0] p);
		int               dur;
		logic [PAT_W-1:0] req;
		buzz_state_t      r;
		case (k)
			KIND_TICK: begin
				if (pat_now != PAT_OFF) begin
					dur = step_ms(pat_now, step_now);
					if (dur == 0) begin
						// end mark: one-shot goes silent, alert loops
						if (one_shot) begin
							pat_now  = PAT_OFF;
							sounding = 1'b0;
						end else begin
							step_now   = '0;
							ms_in_step = '0;
							sounding   = 1'b1;
						end
					end else begin
						if (ms_in_step != '1) ms_in_step = ms_in_step + 1'b1;
						if (int'(ms_in_step) >= dur) begin
							step_now   = step_now + 1'b1;
							ms_in_step = '0;
							sounding   = ~sounding;
						end
					end
				end
			end
			KIND_REQUEST: begin
				req = (p > PAT_SETUP_EXIT) ? PAT_OFF : p;
				// same pattern again is a no-op, except confirm restarts
				if (req != pat_now || req == PAT_CONFIRM) begin
					pat_now    = req;
					step_now   = '0;
					ms_in_step = '0;
					one_shot   = (req >= PAT_CONFIRM);
					sounding   = (req != PAT_OFF);
				end
			end
			KIND_STOP: begin
				// step and elapsed count survive a stop but are hidden
				pat_now  = PAT_OFF;
				sounding = 1'b0;
			end
			default: ;
		endcase
		r.buzzer_on      = sounding;
		r.active_pattern = pat_now;
		r.step_index     = (pat_now != PAT_OFF) ? step_now : '0;
		expected_buzz.push_back(r);
	endtask

	task automatic queue_cmd(input logic [KIND_W-1:0] k, input logic [PAT_W-1:0] p);
		buzz_cmd_t c;
		c.kind    = k;
		c.pattern = p;
		pending_cmds.push_back(c);
	endtask

	// Ticks carry a random pattern field; the block must ignore it.
	task automatic queue_ticks(input int n);
		for (int i = 0; i < n; i++) queue_cmd(KIND_TICK, PAT_W'($urandom_range(0, 7)));
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] want,
		input logic [7:0] got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
	endtask

	// ------------------------------------------------------------------
	// Driver: offers queued transactions, random idle gap after each one.
	// Prediction runs on the edge that accepts a transaction.
	// ------------------------------------------------------------------
	buzz_cmd_t next_cmd;
	int        send_gap;
	logic      drv_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind     <= KIND_TICK;
			pattern  <= PAT_OFF;
			send_gap = 0;
			drv_calm = 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_buzz(kind, pattern);
				n_accepted++;
			end
			// load only when the channel is empty or its transaction just went
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					next_cmd = pending_cmds.pop_front();
					in_valid <= 1'b1;
					kind     <= next_cmd.kind;
					pattern  <= next_cmd.pattern;
					// occasional switch into or out of a back-to-back stretch
					if ($urandom_range(0, 31) == 0) drv_calm = ~drv_calm;
					send_gap = drv_calm ? 0 : $urandom_range(0, MAX_WAIT);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result transaction against the oldest prediction,
	// then drops ready for a random count. Once, a long hold-off lets the
	// pipeline fill so in_ready must fall.
	// ------------------------------------------------------------------
	buzz_state_t want;
	int          recv_gap;
	int          recv_hold;
	logic        mon_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap  = 0;
			recv_hold = 0;
			mon_calm  = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_buzz.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: result transaction with none expected, actual on=%0d pat=%0d step=%0d",
							$time, buzzer_on, active_pattern, step_index);
				end else begin
					want = expected_buzz.pop_front();
					if (buzzer_on !== want.buzzer_on)
						report_mismatch("buzzer_on", 8'(want.buzzer_on), 8'(buzzer_on));
					if (active_pattern !== want.active_pattern)
						report_mismatch("active_pattern", 8'(want.active_pattern),
							8'(active_pattern));
					if (step_index !== want.step_index)
						report_mismatch("step_index", 8'(want.step_index), 8'(step_index));
				end
				n_seen++;
				if (n_seen == HOLD_AT) begin
					recv_hold = HOLD_CYCLES;
				end else begin
					if ($urandom_range(0, 31) == 0) mon_calm = ~mon_calm;
					recv_gap = mon_calm ? 0 : $urandom_range(0, MAX_WAIT);
				end
			end else if (recv_hold > 0) begin
				recv_hold--;
			end else if (recv_gap > 0) begin
				recv_gap--;
			end
			out_ready <= (recv_hold == 0 && recv_gap == 0);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin : stim
		int               pick;
		int               full;
		int               n;
		int               room;
		logic [PAT_W-1:0] p;
		logic [4:0]       played;

		played = '0;

		// directed: idle-state no-ops, every request code, ignore and restart rules
		queue_cmd(KIND_TICK, PAT_UNDEF_C);          // tick while off
		queue_cmd(KIND_UNUSED, PAT_UNDEF_A);        // unused kind
		queue_cmd(KIND_STOP, PAT_OFF);              // stop while off
		queue_cmd(KIND_REQUEST, PAT_UNDEF_A);       // unknown code maps to off
		queue_cmd(KIND_REQUEST, PAT_OFF);
		queue_cmd(KIND_REQUEST, PAT_ALERT);
		queue_cmd(KIND_TICK, PAT_OFF);
		queue_cmd(KIND_REQUEST, PAT_ALERT);         // repeat is ignored
		queue_cmd(KIND_UNUSED, PAT_CONFIRM);
		queue_cmd(KIND_REQUEST, PAT_CONFIRM);
		queue_ticks(2);
		queue_cmd(KIND_REQUEST, PAT_CONFIRM);       // confirm repeat restarts
		queue_cmd(KIND_REQUEST, PAT_SETUP_ENTER);
		queue_cmd(KIND_TICK, PAT_UNDEF_B);
		queue_cmd(KIND_REQUEST, PAT_UNDEF_B);       // unknown code stops it
		queue_cmd(KIND_REQUEST, PAT_SETUP_EXIT);
		queue_ticks(1);
		queue_cmd(KIND_STOP, PAT_UNDEF_C);
		queue_cmd(KIND_TICK, PAT_SETUP_EXIT);       // ignored after stop
		queue_cmd(KIND_REQUEST, PAT_SETUP_EXIT);    // fresh start after stop
		queue_cmd(KIND_REQUEST, PAT_UNDEF_C);
		queue_cmd(KIND_REQUEST, PAT_CONFIRM);
		queue_cmd(KIND_STOP, PAT_CONFIRM);

		// alert runs past its wrap, confirm runs to its switch-off
		queue_cmd(KIND_REQUEST, PAT_ALERT);
		queue_ticks(pattern_ms(PAT_ALERT) + 20);
		queue_cmd(KIND_REQUEST, PAT_CONFIRM);
		queue_ticks(pattern_ms(PAT_CONFIRM) + 2);
		played[PAT_ALERT]   = 1'b1;
		played[PAT_CONFIRM] = 1'b1;

		// random: mostly a request followed by a run of ticks, played to its
		// end mark when it still fits; the rest is noise
		while (pending_cmds.size() < N_ITEMS) begin
			room = N_ITEMS - pending_cmds.size();
			pick = $urandom_range(0, 9);
			if (pick <= 6) begin
				p    = PAT_W'($urandom_range(PAT_ALERT, PAT_SETUP_EXIT));
				full = pattern_ms(p) + 1;
				if (full + 41 < room && (!played[p] || $urandom_range(0, 1) == 1)) begin
					// alert runs past its wrap now and then
					n = full + $urandom_range(0, (p == PAT_ALERT) ? 40 : 3);
					played[p] = 1'b1;
				end else begin
					n = $urandom_range(0, (full < room) ? full : room);
				end
				queue_cmd(KIND_REQUEST, p);
				queue_ticks(n);
			end else if (pick == 7) begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					queue_cmd(KIND_W'($urandom_range(0, 3)), PAT_W'($urandom_range(0, 7)));
			end else if (pick == 8) begin
				queue_cmd(KIND_STOP, PAT_W'($urandom_range(0, 7)));
				queue_ticks($urandom_range(0, 5));
			end else begin
				queue_cmd(KIND_REQUEST, PAT_W'($urandom_range(0, 7)));
				queue_ticks($urandom_range(0, 20));
			end
		end
		n_total = pending_cmds.size();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_total) @(posedge clk);
		while (expected_buzz.size() != 0) @(posedge clk);
		// extra cycles so a stray trailing result still gets caught
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("tb: done, errors");
		$finish;
	end

endmodule
